FILE: design/avtb_pkg.sv
`timescale 1ns / 1ps

package avtb_pkg;

	typedef enum logic [1:0] {
		OP_CLEAR  = 2'd0,
		OP_VERTEX = 2'd1,
		OP_NORMAL = 2'd2,
		OP_POINT  = 2'd3
	} op_t;

	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 63;

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_ROW_X   = 3'd0,
		CFG_ROW_Y   = 3'd1,
		CFG_ROW_Z   = 3'd2,
		CFG_SHIFT_X = 3'd3,
		CFG_SHIFT_Y = 3'd4,
		CFG_SHIFT_Z = 3'd5
	} cfg_idx_t;

	localparam int NUM_AXES = 3;

endpackage

FILE: design/affine_vertex_transform_bounds_top.sv
`timescale 1ns / 1ps
// Results pass through the input, product, sum and result registers to out_valid.
// Throughput: one item per cycle; each stage holds only while the stage after it is full and held.
// Set by the nine parallel coefficient multipliers, one product register each.
// Reset: all stage valids, the bounding box and box_valid clear; rows reset to identity,
// translations to zero.

module affine_vertex_transform_bounds_top
	import avtb_pkg::*;
#(
	parameter int COORD_WIDTH = 32,
	parameter int COEF_WIDTH  = 21
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_write,
	input  logic [CFG_INDEX_W-1:0]        cfg_index,
	input  logic [CFG_DATA_W-1:0]         cfg_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [1:0]                    opcode,
	input  logic signed [COORD_WIDTH-1:0] px,
	input  logic signed [COORD_WIDTH-1:0] py,
	input  logic signed [COORD_WIDTH-1:0] pz,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic signed [COORD_WIDTH-1:0] qx,
	output logic signed [COORD_WIDTH-1:0] qy,
	output logic signed [COORD_WIDTH-1:0] qz,
	output logic signed [COORD_WIDTH-1:0] box_min_x,
	output logic signed [COORD_WIDTH-1:0] box_min_y,
	output logic signed [COORD_WIDTH-1:0] box_min_z,
	output logic signed [COORD_WIDTH-1:0] box_max_x,
	output logic signed [COORD_WIDTH-1:0] box_max_y,
	output logic signed [COORD_WIDTH-1:0] box_max_z,
	output logic                          box_valid,
	output logic                          saturated
);

	localparam int CW    = COORD_WIDTH;
	localparam int KW    = COEF_WIDTH;
	localparam int FRAC  = KW - 3;
	localparam int ROW_W = 3 * KW;
	localparam int PW    = CW + KW;
	localparam int SW    = PW + 2;
	localparam int HW    = SW - FRAC;

	localparam logic signed [SW-1:0] ROUND_HALF =
		{{(SW - FRAC){1'b0}}, 1'b1, {(FRAC - 1){1'b0}}};
	localparam logic signed [CW-1:0] SAT_MAX = {1'b0, {(CW - 1){1'b1}}};
	localparam logic signed [CW-1:0] SAT_MIN = {1'b1, {(CW - 1){1'b0}}};

	// configuration
	logic [ROW_W-1:0]       row_q   [NUM_AXES];
	logic signed [CW-1:0]   shift_q [NUM_AXES];

	// pipeline control
	logic v_s1, v_s2, v_s3, v_s4;
	logic en_s1, en_s2, en_s3, en_s4;

	// payload
	op_t                  op_s1, op_s2, op_s3, op_s4;
	logic signed [CW-1:0] pt_s1   [NUM_AXES];
	logic signed [CW-1:0] pt_s2   [NUM_AXES];
	logic signed [PW-1:0] prod_s2 [NUM_AXES][NUM_AXES];
	logic signed [CW-1:0] q_s3    [NUM_AXES];
	logic                 clip_s3;
	logic signed [CW-1:0] q_s4    [NUM_AXES];
	logic                 clip_s4;

	// bounding box state
	logic signed [CW-1:0] low_q  [NUM_AXES];
	logic signed [CW-1:0] high_q [NUM_AXES];
	logic                 corner_valid_q;

	// combinational sum stage
	logic signed [SW-1:0] acc      [NUM_AXES];
	logic signed [CW-1:0] q_next   [NUM_AXES];
	logic [NUM_AXES-1:0]  clip_ax;

	assign en_s4    = !v_s4 || !out_stall;
	assign en_s3    = !v_s3 || en_s4;
	assign en_s2    = !v_s2 || en_s3;
	assign en_s1    = !v_s1 || en_s2;
	assign in_stall = !en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < NUM_AXES; r++) begin
				row_q[r]   <= ROW_W'({1'b1, {(KW - 3){1'b0}}}) << (r * KW);
				shift_q[r] <= '0;
			end
		end else if (cfg_write) begin
			case (cfg_index)
				CFG_ROW_X:   row_q[0]   <= cfg_data[ROW_W-1:0];
				CFG_ROW_Y:   row_q[1]   <= cfg_data[ROW_W-1:0];
				CFG_ROW_Z:   row_q[2]   <= cfg_data[ROW_W-1:0];
				CFG_SHIFT_X: shift_q[0] <= cfg_data[CW-1:0];
				CFG_SHIFT_Y: shift_q[1] <= cfg_data[CW-1:0];
				CFG_SHIFT_Z: shift_q[2] <= cfg_data[CW-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= in_valid;
			if (en_s2) v_s2 <= v_s1;
			if (en_s3) v_s3 <= v_s2;
			if (en_s4) v_s4 <= v_s3;
		end
	end

	// input register
	always_ff @(posedge clk) begin
		if (in_valid && en_s1) begin
			op_s1    <= op_t'(opcode);
			pt_s1[0] <= px;
			pt_s1[1] <= py;
			pt_s1[2] <= pz;
		end
	end

	// products: row r, column k
	always_ff @(posedge clk) begin
		if (v_s1 && en_s2) begin
			op_s2 <= op_s1;
			for (int r = 0; r < NUM_AXES; r++) begin
				pt_s2[r] <= pt_s1[r];
				for (int k = 0; k < NUM_AXES; k++) begin
					prod_s2[r][k] <= $signed(row_q[r][k*KW +: KW]) * pt_s1[k];
				end
			end
		end
	end

	// sum, round half up, drop fraction, saturate; points and clears pass the point through
	always_comb begin
		for (int r = 0; r < NUM_AXES; r++) begin
			acc[r] = SW'(prod_s2[r][0]) + SW'(prod_s2[r][1]) + SW'(prod_s2[r][2])
				+ ((op_s2 == OP_VERTEX) ? (SW'(shift_q[r]) <<< FRAC) : SW'(0))
				+ ROUND_HALF;
			clip_ax[r] = !((acc[r][SW-1:FRAC+CW-1] == '0)
				|| (acc[r][SW-1:FRAC+CW-1] == {(HW - CW + 1){1'b1}}));
			if (op_s2 == OP_VERTEX || op_s2 == OP_NORMAL) begin
				if (clip_ax[r]) begin
					q_next[r] = acc[r][SW-1] ? SAT_MIN : SAT_MAX;
				end else begin
					q_next[r] = acc[r][FRAC+CW-1:FRAC];
				end
			end else begin
				q_next[r] = pt_s2[r];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (v_s2 && en_s3) begin
			op_s3   <= op_s2;
			q_s3    <= q_next;
			clip_s3 <= (op_s2 == OP_VERTEX || op_s2 == OP_NORMAL) && (|clip_ax);
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (v_s3 && en_s4) begin
			op_s4   <= op_s3;
			q_s4    <= q_s3;
			clip_s4 <= clip_s3;
		end
	end

	// box moves only when a result enters the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < NUM_AXES; r++) begin
				low_q[r]  <= '0;
				high_q[r] <= '0;
			end
			corner_valid_q <= 1'b0;
		end else if (v_s3 && en_s4) begin
			case (op_s3)
				OP_CLEAR: begin
					for (int r = 0; r < NUM_AXES; r++) begin
						low_q[r]  <= '0;
						high_q[r] <= '0;
					end
					corner_valid_q <= 1'b0;
				end
				OP_VERTEX, OP_POINT: begin
					for (int r = 0; r < NUM_AXES; r++) begin
						if (!corner_valid_q || q_s3[r] < low_q[r]) low_q[r] <= q_s3[r];
						if (!corner_valid_q || q_s3[r] > high_q[r]) high_q[r] <= q_s3[r];
					end
					corner_valid_q <= 1'b1;
				end
				default: ;
			endcase
		end
	end

	assign out_valid = v_s4;
	assign qx        = q_s4[0];
	assign qy        = q_s4[1];
	assign qz        = q_s4[2];
	assign saturated = clip_s4;
	assign box_min_x = low_q[0];
	assign box_min_y = low_q[1];
	assign box_min_z = low_q[2];
	assign box_max_x = high_q[0];
	assign box_max_y = high_q[1];
	assign box_max_z = high_q[2];
	assign box_valid = corner_valid_q;

	a_box_ordered: assert property (@(posedge clk) disable iff (!arst_n)
		corner_valid_q |-> (low_q[0] <= high_q[0]) && (low_q[1] <= high_q[1])
			&& (low_q[2] <= high_q[2]))
		else $error("bounding box corners out of order");

	a_box_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(low_q[0]) && $stable(high_q[2])
			&& $stable(corner_valid_q))
		else $error("bounding box changed under a held result");

	a_clear_empties: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && op_s4 == OP_CLEAR |-> !box_valid && !saturated)
		else $error("clear item left a box or a clip flag");

	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> v_s1 && v_s2 && v_s3 && v_s4 && out_stall)
		else $error("input stalled with room in the pipeline");

endmodule

FILE: tb/sv/affine_vertex_transform_bounds_top_test.sv
`timescale 1ns / 1ps

module affine_vertex_transform_bounds_top_test
	import avtb_pkg::*;
();

	localparam int    COORD_W     = 32;
	localparam int    COEF_W      = 21;
	localparam int    COEF_FRAC   = COEF_W - 3;
	localparam int    ROW_W       = 3 * COEF_W;
	localparam int    LATENCY     = 4;
	localparam int    IDLE_PCT    = 18;
	localparam int    HOLD_CYCLES = 300;
	localparam int    STALL_LIMIT = 5000;
	localparam int    PHASE_ITEMS = 250;
	localparam int    NUM_PHASES  = 6;
	localparam longint COEF_ONE   = 64'sd1 <<< COEF_FRAC;
	localparam longint COORD_MAX  = 64'sd2147483647;
	localparam longint COORD_MIN  = -64'sd2147483648;

	localparam logic signed [COORD_W-1:0] MAXC = 32'sh7FFF_FFFF;
	localparam logic signed [COORD_W-1:0] MINC = 32'sh8000_0000;
	localparam logic signed [COORD_W-1:0] UNIT = 32'sh0001_0000;
	localparam logic [COEF_W-1:0] COEF_MAX   = 21'h0F_FFFF;
	localparam logic [COEF_W-1:0] COEF_MIN   = 21'h10_0000;
	localparam logic [COEF_W-1:0] COEF_P1    = 21'h04_0000;
	localparam logic [COEF_W-1:0] COEF_M1    = 21'h1C_0000;

	typedef struct packed {
		logic [2:0][COORD_W-1:0] q;
		logic [2:0][COORD_W-1:0] lo;
		logic [2:0][COORD_W-1:0] hi;
		logic                    box_on;
		logic                    sat;
	} vertex_result_t;

	class vertex_box_scoreboard;
		logic [ROW_W-1:0]          rows[3];
		logic signed [COORD_W-1:0] shifts[3];
		logic signed [COORD_W-1:0] low_corner[3];
		logic signed [COORD_W-1:0] high_corner[3];
		bit                        box_on;
		vertex_result_t            pending_results[$];
		int                        errors;
		string                     axis_name[3];

		function new();
			int a;
			for (a = 0; a < 3; a++) begin
				rows[a]        = ROW_W'(COEF_ONE) << (a * COEF_W);
				shifts[a]      = '0;
				low_corner[a]  = '0;
				high_corner[a] = '0;
			end
			box_on    = 1'b0;
			errors    = 0;
			axis_name = '{"x", "y", "z"};
		endfunction

		function void set_register(cfg_idx_t idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				CFG_ROW_X:   rows[0]   = data[ROW_W-1:0];
				CFG_ROW_Y:   rows[1]   = data[ROW_W-1:0];
				CFG_ROW_Z:   rows[2]   = data[ROW_W-1:0];
				CFG_SHIFT_X: shifts[0] = data[COORD_W-1:0];
				CFG_SHIFT_Y: shifts[1] = data[COORD_W-1:0];
				CFG_SHIFT_Z: shifts[2] = data[COORD_W-1:0];
				default: ;
			endcase
		endfunction

		// Exact dot product, round half up, saturate to the coordinate range.
		function logic signed [COORD_W-1:0] transform_axis(int axis, bit affine,
				logic signed [COORD_W-1:0] p[3], inout bit clip);
			longint                   acc;
			logic signed [COEF_W-1:0] c;
			int                       k;
			acc = COEF_ONE >>> 1;
			for (k = 0; k < 3; k++) begin
				c = rows[axis][k*COEF_W +: COEF_W];
				acc += longint'(c) * longint'(p[k]);
			end
			if (affine)
				acc += longint'(shifts[axis]) * COEF_ONE;
			acc = acc >>> COEF_FRAC;
			if (acc > COORD_MAX) begin
				clip = 1'b1;
				return MAXC;
			end
			if (acc < COORD_MIN) begin
				clip = 1'b1;
				return MINC;
			end
			return COORD_W'(acc);
		endfunction

		function void grow_box(logic signed [COORD_W-1:0] v[3]);
			int a;
			for (a = 0; a < 3; a++) begin
				if (!box_on) begin
					low_corner[a]  = v[a];
					high_corner[a] = v[a];
				end else begin
					if (v[a] < low_corner[a])  low_corner[a]  = v[a];
					if (v[a] > high_corner[a]) high_corner[a] = v[a];
				end
			end
			box_on = 1'b1;
		endfunction

		function void note_point(op_t op, logic signed [COORD_W-1:0] x,
				logic signed [COORD_W-1:0] y, logic signed [COORD_W-1:0] z);
			vertex_result_t            r;
			logic signed [COORD_W-1:0] p[3];
			logic signed [COORD_W-1:0] t[3];
			bit                        clip;
			int                        a;
			p    = '{x, y, z};
			t    = p;
			clip = 1'b0;
			case (op)
				OP_CLEAR: begin
					for (a = 0; a < 3; a++) begin
						low_corner[a]  = '0;
						high_corner[a] = '0;
					end
					box_on = 1'b0;
				end
				OP_VERTEX, OP_NORMAL: begin
					for (a = 0; a < 3; a++)
						t[a] = transform_axis(a, op == OP_VERTEX, p, clip);
					if (op == OP_VERTEX)
						grow_box(t);
				end
				default: grow_box(p);
			endcase
			for (a = 0; a < 3; a++) begin
				r.q[a]  = t[a];
				r.lo[a] = low_corner[a];
				r.hi[a] = high_corner[a];
			end
			r.box_on = box_on;
			r.sat    = clip;
			pending_results.push_back(r);
		endfunction

		task report(string what);
			errors++;
			$display("[%0t] MISMATCH %s", $realtime, what);
		endtask

		task compare_field(string name, logic [COORD_W-1:0] got, logic [COORD_W-1:0] want);
			if (got !== want)
				report($sformatf("%s: got %h, want %h", name, got, want));
		endtask

		task check_result(vertex_result_t got);
			vertex_result_t want;
			int             a;
			if (pending_results.size() == 0) begin
				report("result arrived with no item outstanding");
				return;
			end
			want = pending_results.pop_front();
			for (a = 0; a < 3; a++) begin
				compare_field({"q", axis_name[a]}, got.q[a], want.q[a]);
				compare_field({"box_min_", axis_name[a]}, got.lo[a], want.lo[a]);
				compare_field({"box_max_", axis_name[a]}, got.hi[a], want.hi[a]);
			end
			compare_field("box_valid", COORD_W'(got.box_on), COORD_W'(want.box_on));
			compare_field("saturated", COORD_W'(got.sat), COORD_W'(want.sat));
		endtask

		function int pending();
			return pending_results.size();
		endfunction
	endclass

	logic                         clk       = 1'b0;
	logic                         arst_n    = 1'b0;
	logic                         cfg_write = 1'b0;
	cfg_idx_t                     cfg_index = CFG_ROW_X;
	logic [CFG_DATA_W-1:0]        cfg_data  = '0;
	logic                         in_valid  = 1'b0;
	logic                         in_stall;
	logic [1:0]                   opcode    = OP_CLEAR;
	logic signed [COORD_W-1:0]    px        = '0;
	logic signed [COORD_W-1:0]    py        = '0;
	logic signed [COORD_W-1:0]    pz        = '0;
	logic                         out_valid;
	logic                         out_stall = 1'b0;
	logic signed [COORD_W-1:0]    qx, qy, qz;
	logic signed [COORD_W-1:0]    box_min_x, box_min_y, box_min_z;
	logic signed [COORD_W-1:0]    box_max_x, box_max_y, box_max_z;
	logic                         box_valid;
	logic                         saturated;

	vertex_box_scoreboard sb = new();
	bit                   calm     = 1'b0;
	bit                   hold_req = 1'b0;
	int                   quiet_cycles = 0;

	affine_vertex_transform_bounds_top #(
		.COORD_WIDTH(COORD_W),
		.COEF_WIDTH (COEF_W)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.opcode   (opcode),
		.px       (px),
		.py       (py),
		.pz       (pz),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.qx       (qx),
		.qy       (qy),
		.qz       (qz),
		.box_min_x(box_min_x),
		.box_min_y(box_min_y),
		.box_min_z(box_min_z),
		.box_max_x(box_max_x),
		.box_max_y(box_max_y),
		.box_max_z(box_max_z),
		.box_valid(box_valid),
		.saturated(saturated)
	);

	always #5 clk = ~clk;

	// Receiver: random stalls, one long hold-off on request.
	initial begin
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
			end
		end
	end

	always @(posedge clk) begin
		vertex_result_t got;
		if (arst_n && out_valid && !out_stall) begin
			got.q    = {qz, qy, qx};
			got.lo   = {box_min_z, box_min_y, box_min_x};
			got.hi   = {box_max_z, box_max_y, box_max_x};
			got.box_on = box_valid;
			got.sat  = saturated;
			sb.check_result(got);
		end
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("affine_vertex_transform_bounds_top verification failed");
			$finish;
		end
	end

	task automatic send_item(op_t op, logic signed [COORD_W-1:0] x,
			logic signed [COORD_W-1:0] y, logic signed [COORD_W-1:0] z);
		while (!calm && $urandom_range(99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		opcode   <= op;
		px       <= x;
		py       <= y;
		pz       <= z;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		sb.note_point(op, x, y, z);
	endtask

	task automatic write_register(cfg_idx_t idx, logic [CFG_DATA_W-1:0] data);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		sb.set_register(idx, data);
	endtask

	task automatic program_transform(logic [ROW_W-1:0] rx, logic [ROW_W-1:0] ry,
			logic [ROW_W-1:0] rz, logic signed [COORD_W-1:0] sx,
			logic signed [COORD_W-1:0] sy, logic signed [COORD_W-1:0] sz);
		write_register(CFG_ROW_X, rx);
		write_register(CFG_ROW_Y, ry);
		write_register(CFG_ROW_Z, rz);
		write_register(CFG_SHIFT_X, CFG_DATA_W'(sx));
		write_register(CFG_SHIFT_Y, CFG_DATA_W'(sy));
		write_register(CFG_SHIFT_Z, CFG_DATA_W'(sz));
		cfg_write <= 1'b0;
	endtask

	// Drop valid, then wait out every outstanding result and the pipeline depth.
	task automatic drain();
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	function automatic logic signed [COORD_W-1:0] small_value();
		return $urandom_range(0, 32'h00FF_FFFF) - 32'h0080_0000;
	endfunction

	function automatic logic signed [COORD_W-1:0] rand_coord();
		case ($urandom_range(9))
			0: begin
				case ($urandom_range(3))
					0: return MAXC;
					1: return MINC;
					2: return '0;
					default: return -1;
				endcase
			end
			1, 2, 3, 4: return $urandom;
			default: return small_value();
		endcase
	endfunction

	function automatic logic [COEF_W-1:0] rand_coef(int style);
		case (style)
			1: return COEF_W'($urandom_range(0, 32'h0008_0000) - 32'h0004_0000);
			3: begin
				case ($urandom_range(4))
					0: return COEF_MIN;
					1: return COEF_MAX;
					2: return '0;
					3: return COEF_P1;
					default: return COEF_M1;
				endcase
			end
			default: return COEF_W'($urandom);
		endcase
	endfunction

	function automatic logic [ROW_W-1:0] rand_row(int style, int axis);
		logic [63:0] w;
		if (style == 0)
			return ROW_W'(COEF_ONE) << (axis * COEF_W);
		if (style == 2) begin
			w = {$urandom, $urandom};
			return w[ROW_W-1:0];
		end
		return {rand_coef(style), rand_coef(style), rand_coef(style)};
	endfunction

	function automatic logic signed [COORD_W-1:0] rand_shift(int style);
		if (style == 2)
			return $urandom;
		if (style == 3) begin
			case ($urandom_range(3))
				0: return MAXC;
				1: return MINC;
				2: return '0;
				default: return $urandom;
			endcase
		end
		return small_value();
	endfunction

	task automatic random_item();
		int  r;
		op_t op;
		r = $urandom_range(99);
		if (r < 6)
			op = OP_CLEAR;
		else if (r < 50)
			op = OP_VERTEX;
		else if (r < 70)
			op = OP_NORMAL;
		else
			op = OP_POINT;
		send_item(op, rand_coord(), rand_coord(), rand_coord());
	endtask

	initial begin
		int ph;
		int n;
		int style;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset transform is the identity: empty box, first point, clear, pass-through.
		send_item(OP_NORMAL, UNIT, 2 * UNIT, -3 * UNIT);
		send_item(OP_POINT, MINC, MAXC, '0);
		send_item(OP_POINT, MAXC, MINC, -1);
		send_item(OP_VERTEX, '0, '0, '0);
		send_item(OP_CLEAR, MAXC, MINC, MAXC);
		send_item(OP_VERTEX, -UNIT, UNIT, 7);
		send_item(OP_VERTEX, MAXC, MAXC, MAXC);
		send_item(OP_NORMAL, MINC, MINC, MINC);
		drain();

		// Largest coefficients and shifts: overflow both ways.
		program_transform({3{COEF_MAX}}, {3{COEF_MAX}}, {3{COEF_MAX}}, MAXC, MAXC, MAXC);
		send_item(OP_VERTEX, MAXC, MAXC, MAXC);
		send_item(OP_VERTEX, MINC, MINC, MINC);
		send_item(OP_NORMAL, UNIT, -UNIT, '0);
		send_item(OP_POINT, 1, 2, 3);
		send_item(OP_CLEAR, '0, '0, '0);
		send_item(OP_VERTEX, '0, '0, '0);
		drain();

		program_transform({3{COEF_MIN}}, {3{COEF_MIN}}, {3{COEF_MIN}}, MINC, MINC, MINC);
		send_item(OP_VERTEX, MINC, MINC, MINC);
		send_item(OP_VERTEX, MAXC, MAXC, MAXC);
		send_item(OP_VERTEX, '0, '0, '0);
		send_item(OP_NORMAL, '0, '0, '0);
		drain();

		// Smallest coefficient on the diagonal: rounding at the half step.
		program_transform(ROW_W'(1), ROW_W'(1) << COEF_W, ROW_W'(1) << (2 * COEF_W),
			'0, '0, '0);
		send_item(OP_VERTEX, 32'sd131072, 32'sd131072, 32'sd131072);
		send_item(OP_VERTEX, -32'sd131072, -32'sd131071, 32'sd131071);
		send_item(OP_VERTEX, 32'sd393216, -32'sd393216, MINC);
		drain();

		for (ph = 0; ph < NUM_PHASES; ph++) begin
			style = ph % 4;
			calm  = (ph == 2);
			program_transform(rand_row(style, 0), rand_row(style, 1), rand_row(style, 2),
				rand_shift(style), rand_shift(style), rand_shift(style));
			for (n = 0; n < PHASE_ITEMS; n++) begin
				if (ph == 1 && n == 100)
					hold_req = 1'b1;
				random_item();
			end
			drain();
		end
		calm = 1'b0;

		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("affine_vertex_transform_bounds_top verification clean");
		end else begin
			$display("affine_vertex_transform_bounds_top verification failed");
		end
		$finish;
	end

endmodule

FILE: files.f
design/avtb_pkg.sv
design/affine_vertex_transform_bounds_top.sv
tb/sv/affine_vertex_transform_bounds_top_test.sv
